// ===== rtl/fisc_pkg.sv =====
// Shared types and constants for the firmware image stream checker.
`timescale 1ns / 1ps

package fisc_pkg;

    // Default sizes of the header capture and of the marker window
    localparam int HEADER_BYTES_DEF = 24;
    localparam int MARK_LEN_DEF     = 27;
    localparam int MARK_MAX         = 32;

    // Smallest image that a start request accepts
    localparam logic [23:0] MIN_IMAGE = 24'd4096;

    // Header positions of the little-endian chip id
    localparam int CHIP_LOW_POS  = 12;
    localparam int CHIP_HIGH_POS = 13;

    // Register reset values
    localparam logic [23:0] DECLARED_SIZE_RST = 24'd0;
    localparam logic [23:0] MAX_SIZE_RST      = 24'hFFFFFF;
    localparam logic [7:0]  MAGIC_BYTE_RST    = 8'd233;
    localparam logic [15:0] CHIP_CODE_RST     = 16'd9;

    // Fixed marker string, padded with zero bytes
    localparam logic [7:0] MARK_TEXT [MARK_MAX] = '{
        8'h54, 8'h52, 8'h49, 8'h4D, 8'h42, 8'h4F, 8'h58, 8'h2D,
        8'h53, 8'h33, 8'h2D, 8'h46, 8'h49, 8'h52, 8'h4D, 8'h57,
        8'h41, 8'h52, 8'h45, 8'h2D, 8'h4D, 8'h41, 8'h52, 8'h4B,
        8'h2D, 8'h76, 8'h31, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    // Request kinds
    typedef enum logic [1:0] {
        ACT_START  = 2'd0,
        ACT_DATA   = 2'd1,
        ACT_FINISH = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    // Result codes
    typedef enum logic [3:0] {
        ST_OK         = 4'd0,
        ST_TOO_SMALL  = 4'd1,
        ST_TOO_LARGE  = 4'd2,
        ST_OVERFLOW   = 4'd3,
        ST_BAD_MAGIC  = 4'd4,
        ST_WRONG_CHIP = 4'd5,
        ST_INCOMPLETE = 4'd6,
        ST_NO_HEADER  = 4'd7,
        ST_NO_MARKER  = 4'd8
    } status_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_DECLARED_SIZE = 2'd0,
        REG_MAX_SIZE      = 2'd1,
        REG_MAGIC_BYTE    = 2'd2,
        REG_CHIP_CODE     = 2'd3
    } reg_idx_t;

endpackage

// ===== rtl/firmware_image_stream_checker.sv =====
// Top level of the firmware image stream checker: request register, check logic, result register.
`timescale 1ns / 1ps

// Firmware image stream checker. Each request (start, data byte or finish) is
// taken into an input register, checked against the transfer state and gives
// exactly one result (status code, marker_seen, header_done) in an output
// register. The block takes one request per cycle while no result waits on
// m_ready; the byte counter, header capture and marker window compare all update
// in the one check stage, which sets that rate. A result waiting on m_ready
// stalls the check stage; a new request then enters the input register only
// while it is empty. Configuration registers sit on the APB port at byte addresses 0
// (declared_size), 4 (max_size), 8 (magic_byte) and 12 (chip_code); write them only while idle.
module firmware_image_stream_checker #(
    parameter int HEADER_BYTES = fisc_pkg::HEADER_BYTES_DEF,
    parameter int MARK_LEN     = fisc_pkg::MARK_LEN_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input request channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [7:0]  s_data_byte,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_status,
    output logic        m_marker_seen,
    output logic        m_header_done,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import fisc_pkg::*;

    localparam int HC_W = $clog2(HEADER_BYTES + 1);
    localparam int WF_W = $clog2(MARK_LEN + 1);

    // configuration registers
    logic [23:0] declared_size_reg;
    logic [23:0] max_size_reg;
    logic [7:0]  magic_byte_reg;
    logic [15:0] chip_code_reg;
    reg_idx_t    cfg_idx;
    logic        cfg_wr;

    // request register
    logic        in_valid_reg;
    action_t     in_action_reg;
    logic [7:0]  in_byte_reg;

    // transfer state
    logic [23:0]     received_count_reg, received_count_next;
    logic [HC_W-1:0] header_count_reg, header_count_next;
    logic [7:0]      header_first_reg, header_first_next;
    logic [7:0]      chip_low_reg, chip_low_next;
    logic [7:0]      chip_high_reg, chip_high_next;
    logic            header_checked_reg, header_checked_next;
    logic [7:0]      window_bytes_reg [MARK_LEN];
    logic [7:0]      window_bytes_next [MARK_LEN];
    logic [WF_W-1:0] window_fill_reg, window_fill_next;
    logic            marker_found_reg, marker_found_next;

    // result register
    logic        out_valid_reg;
    status_t     out_status_reg, status_next;
    logic        out_marker_reg;
    logic        out_header_reg;

    logic        advance;
    logic        take;
    logic        mark_match;

    // APB access
    assign pready  = 1'b1;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_comb begin
        case (cfg_idx)
            REG_DECLARED_SIZE: prdata = {8'd0, declared_size_reg};
            REG_MAX_SIZE:      prdata = {8'd0, max_size_reg};
            REG_MAGIC_BYTE:    prdata = {24'd0, magic_byte_reg};
            REG_CHIP_CODE:     prdata = {16'd0, chip_code_reg};
            default:           prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            declared_size_reg <= DECLARED_SIZE_RST;
            max_size_reg      <= MAX_SIZE_RST;
            magic_byte_reg    <= MAGIC_BYTE_RST;
            chip_code_reg     <= CHIP_CODE_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_DECLARED_SIZE: declared_size_reg <= pwdata[23:0];
                REG_MAX_SIZE:      max_size_reg      <= pwdata[23:0];
                REG_MAGIC_BYTE:    magic_byte_reg    <= pwdata[7:0];
                REG_CHIP_CODE:     chip_code_reg     <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // handshake: the check stage moves when the result register is free
    assign advance = !out_valid_reg || m_ready;
    assign take    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    // request register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_action_reg <= action_t'(s_action);
            in_byte_reg   <= s_data_byte;
        end
    end

    // marker compare against the shifted window
    always_comb begin
        for (int i = 0; i < MARK_LEN - 1; i++) begin
            window_bytes_next[i] = window_bytes_reg[i + 1];
        end
        window_bytes_next[MARK_LEN-1] = in_byte_reg;
        mark_match = 1'b1;
        for (int i = 0; i < MARK_LEN; i++) begin
            if (window_bytes_next[i] != MARK_TEXT[i]) begin
                mark_match = 1'b0;
            end
        end
    end

    // next transfer state and status
    always_comb begin
        received_count_next = received_count_reg;
        header_count_next   = header_count_reg;
        header_first_next   = header_first_reg;
        chip_low_next       = chip_low_reg;
        chip_high_next      = chip_high_reg;
        header_checked_next = header_checked_reg;
        window_fill_next    = window_fill_reg;
        marker_found_next   = marker_found_reg;
        status_next         = ST_OK;

        case (in_action_reg)
            ACT_START: begin
                received_count_next = '0;
                header_count_next   = '0;
                header_first_next   = '0;
                chip_low_next       = '0;
                chip_high_next      = '0;
                header_checked_next = 1'b0;
                window_fill_next    = '0;
                marker_found_next   = 1'b0;
                if (declared_size_reg < MIN_IMAGE) begin
                    status_next = ST_TOO_SMALL;
                end else if (declared_size_reg > max_size_reg) begin
                    status_next = ST_TOO_LARGE;
                end
            end
            ACT_DATA: begin
                if (received_count_reg >= declared_size_reg) begin
                    status_next = ST_OVERFLOW;
                end else begin
                    // header capture
                    if (header_count_reg < HC_W'(HEADER_BYTES)) begin
                        if (header_count_reg == '0) begin
                            header_first_next = in_byte_reg;
                        end
                        if (header_count_reg == HC_W'(CHIP_LOW_POS)) begin
                            chip_low_next = in_byte_reg;
                        end
                        if (header_count_reg == HC_W'(CHIP_HIGH_POS)) begin
                            chip_high_next = in_byte_reg;
                        end
                        header_count_next = header_count_reg + 1'b1;
                    end
                    // marker window
                    if (!marker_found_reg) begin
                        if (window_fill_reg < WF_W'(MARK_LEN)) begin
                            window_fill_next = window_fill_reg + 1'b1;
                        end
                        if (window_fill_reg >= WF_W'(MARK_LEN - 1) && mark_match) begin
                            marker_found_next = 1'b1;
                        end
                    end
                    received_count_next = received_count_reg + 24'd1;
                    // header check, once, on the completing byte
                    if (!header_checked_reg && header_count_next == HC_W'(HEADER_BYTES)) begin
                        header_checked_next = 1'b1;
                        if (header_first_next != magic_byte_reg) begin
                            status_next = ST_BAD_MAGIC;
                        end else if ({chip_high_next, chip_low_next} != chip_code_reg) begin
                            status_next = ST_WRONG_CHIP;
                        end
                    end
                end
            end
            ACT_FINISH: begin
                if (received_count_reg != declared_size_reg) begin
                    status_next = ST_INCOMPLETE;
                end else if (!header_checked_reg) begin
                    status_next = ST_NO_HEADER;
                end else if (!marker_found_reg) begin
                    status_next = ST_NO_MARKER;
                end
            end
            default: ;
        endcase
    end

    // transfer state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            received_count_reg <= '0;
            header_count_reg   <= '0;
            header_first_reg   <= '0;
            chip_low_reg       <= '0;
            chip_high_reg      <= '0;
            header_checked_reg <= 1'b0;
            window_fill_reg    <= '0;
            marker_found_reg   <= 1'b0;
        end else if (take) begin
            received_count_reg <= received_count_next;
            header_count_reg   <= header_count_next;
            header_first_reg   <= header_first_next;
            chip_low_reg       <= chip_low_next;
            chip_high_reg      <= chip_high_next;
            header_checked_reg <= header_checked_next;
            window_fill_reg    <= window_fill_next;
            marker_found_reg   <= marker_found_next;
        end
    end

    // window shift line; contents only matter once it has filled
    always_ff @(posedge aclk) begin
        if (take && in_action_reg == ACT_DATA && !marker_found_reg
            && received_count_reg < declared_size_reg) begin
            window_bytes_reg <= window_bytes_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            out_status_reg <= status_next;
            out_marker_reg <= marker_found_next;
            out_header_reg <= header_checked_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_status      = out_status_reg;
    assign m_marker_seen = out_marker_reg;
    assign m_header_done = out_header_reg;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the firmware image stream checker.
`timescale 1ns / 1ps

module tb_top;
    import fisc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        action_t    act;
        logic [7:0] data;
    } image_request_t;

    typedef struct packed {
        status_t status;
        logic    marker;
        logic    header;
    } image_result_t;

    // Clock, reset and DUT ports
    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    action_t     s_action = ACT_START;
    logic [7:0]  s_data_byte = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [3:0]  m_status;
    logic        m_marker_seen;
    logic        m_header_done;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = 4'h0;
    logic [31:0] pwdata = 32'h0;
    logic [31:0] prdata;
    logic        pready;

    // Stimulus and scoreboard bookkeeping
    image_request_t pend_requests [$];
    image_result_t  expected_results [$];
    int             items_queued = 0;
    int             items_accepted = 0;
    int             fail_count = 0;
    int             cycle_count = 0;
    int             send_idle_pct = 0;
    int             recv_idle_pct = 0;
    logic           s_taken = 1'b0;

    // Register copies and transfer state of the predictor
    logic [23:0] cfg_declared;
    logic [23:0] cfg_max;
    logic [7:0]  cfg_magic;
    logic [15:0] cfg_chip;
    logic [23:0] byte_count;
    int          hdr_count;
    logic [7:0]  hdr_first;
    logic [7:0]  chip_lo;
    logic [7:0]  chip_hi;
    logic        hdr_checked;
    logic [7:0]  mark_window [MARK_LEN_DEF];
    int          win_fill;
    logic        marker_hit;

    firmware_image_stream_checker i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_data_byte   (s_data_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_marker_seen (m_marker_seen),
        .m_header_done (m_header_done),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #4 aclk = ~aclk;

    // Start of a new image: wipe counters, header capture and marker window
    task automatic clear_transfer();
        byte_count  = '0;
        hdr_count   = 0;
        hdr_first   = '0;
        chip_lo     = '0;
        chip_hi     = '0;
        hdr_checked = 1'b0;
        for (int k = 0; k < MARK_LEN_DEF; k++) mark_window[k] = '0;
        win_fill    = 0;
        marker_hit  = 1'b0;
    endtask

    // Expected status and flags for one request; updates the transfer state
    task automatic predict_status(input action_t act, input logic [7:0] d,
                                  output image_result_t r);
        status_t st;
        logic    hit;
        st = ST_OK;
        case (act)
            ACT_START: begin
                clear_transfer();
                if (cfg_declared < MIN_IMAGE) st = ST_TOO_SMALL;
                else if (cfg_declared > cfg_max) st = ST_TOO_LARGE;
            end
            ACT_DATA: begin
                if (byte_count >= cfg_declared) begin
                    st = ST_OVERFLOW;
                end else begin
                    // header capture
                    if (hdr_count < HEADER_BYTES_DEF) begin
                        if (hdr_count == 0) hdr_first = d;
                        if (hdr_count == CHIP_LOW_POS) chip_lo = d;
                        if (hdr_count == CHIP_HIGH_POS) chip_hi = d;
                        hdr_count++;
                    end
                    // sliding marker window, frozen once the marker is found
                    if (!marker_hit) begin
                        if (win_fill >= MARK_LEN_DEF) begin
                            for (int k = 0; k < MARK_LEN_DEF - 1; k++)
                                mark_window[k] = mark_window[k + 1];
                            win_fill = MARK_LEN_DEF - 1;
                        end
                        mark_window[win_fill] = d;
                        win_fill++;
                        if (win_fill == MARK_LEN_DEF) begin
                            hit = 1'b1;
                            for (int k = 0; k < MARK_LEN_DEF; k++)
                                if (mark_window[k] != MARK_TEXT[k]) hit = 1'b0;
                            marker_hit = hit;
                        end
                    end
                    byte_count = byte_count + 24'd1;
                    // one-time header check, magic before chip id
                    if (!hdr_checked && hdr_count == HEADER_BYTES_DEF) begin
                        hdr_checked = 1'b1;
                        if (hdr_first != cfg_magic) st = ST_BAD_MAGIC;
                        else if ({chip_hi, chip_lo} != cfg_chip) st = ST_WRONG_CHIP;
                    end
                end
            end
            ACT_FINISH: begin
                if (byte_count != cfg_declared) st = ST_INCOMPLETE;
                else if (!hdr_checked) st = ST_NO_HEADER;
                else if (!marker_hit) st = ST_NO_MARKER;
            end
            default: ;
        endcase
        r.status = st;
        r.marker = marker_hit;
        r.header = hdr_checked;
    endtask

    task automatic push_req(input action_t act, input logic [7:0] d);
        pend_requests.push_back('{act: act, data: d});
        items_queued++;
    endtask

    // Block until every request is taken and every result has come back
    task automatic wait_drained();
        while (items_accepted != items_queued || expected_results.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // APB write (setup + access), only once the block has drained
    task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
        wait_drained();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_DECLARED_SIZE: cfg_declared = val[23:0];
            REG_MAX_SIZE:      cfg_max      = val[23:0];
            REG_MAGIC_BYTE:    cfg_magic    = val[7:0];
            REG_CHIP_CODE:     cfg_chip     = val[15:0];
            default: ;
        endcase
    endtask

    task automatic random_reg_write();
        reg_idx_t idx;
        idx = reg_idx_t'($urandom_range(3));
        case (idx)
            REG_DECLARED_SIZE: write_reg(idx, $urandom_range(10, 80));
            REG_MAX_SIZE:      write_reg(idx, $urandom_range(1) ? 32'hFFFFFF
                                                   : $urandom_range(0, 24'hFFFFFF));
            default:           write_reg(idx, $urandom);
        endcase
    endtask

    // One transfer: start, sent data bytes (the len image bytes first, random after), finish
    task automatic queue_image(input int len, input int sent, input bit good_magic,
                               input bit good_chip, input bit put_marker,
                               input bit mid_write);
        logic [7:0]  img [$];
        logic [15:0] chip;
        int          pos;
        for (int k = 0; k < len; k++) img.push_back(8'($urandom_range(255)));
        chip = good_chip ? cfg_chip : cfg_chip ^ 16'($urandom_range(1, 65535));
        if (len > 0) img[0] = good_magic ? cfg_magic : cfg_magic ^ 8'($urandom_range(1, 255));
        if (len > CHIP_HIGH_POS) begin
            img[CHIP_LOW_POS]  = chip[7:0];
            img[CHIP_HIGH_POS] = chip[15:8];
        end
        if (put_marker && len >= MARK_LEN_DEF) begin
            // keep the marker clear of the chip id bytes when the image allows it
            if (len - MARK_LEN_DEF >= CHIP_HIGH_POS + 1)
                pos = $urandom_range(CHIP_HIGH_POS + 1, len - MARK_LEN_DEF);
            else
                pos = $urandom_range(0, len - MARK_LEN_DEF);
            for (int k = 0; k < MARK_LEN_DEF; k++) img[pos + k] = MARK_TEXT[k];
        end
        push_req(ACT_START, 8'($urandom_range(255)));
        for (int k = 0; k < sent; k++) begin
            if (mid_write && k == sent / 2) random_reg_write();
            if ($urandom_range(99) < 4) push_req(ACT_NONE, 8'($urandom_range(255)));
            if ($urandom_range(99) < 2) push_req(ACT_FINISH, 8'($urandom_range(255)));
            push_req(ACT_DATA, (k < len) ? img[k] : 8'($urandom_range(255)));
        end
        push_req(ACT_FINISH, 8'($urandom_range(255)));
    endtask

    task automatic note_failure(input string msg);
        if (fail_count < 10) $display("tb_top: %s", msg);
        fail_count++;
    endtask

    // Driver: holds a request until accepted, then loads the next one or idles
    always @(negedge aclk) begin
        image_request_t req;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_taken) begin
            if (pend_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                req = pend_requests.pop_front();
                s_valid     <= 1'b1;
                s_action    <= req.act;
                s_data_byte <= req.data;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver backpressure
    always @(negedge aclk) begin
        m_ready <= aresetn && ($urandom_range(99) >= recv_idle_pct);
    end

    // Request acceptance: predict and store the expected result
    always @(posedge aclk) begin
        image_result_t r;
        s_taken <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            predict_status(s_action, s_data_byte, r);
            expected_results.push_back(r);
            items_accepted++;
        end
    end

    // Monitor: compare each result with the oldest expectation
    always @(posedge aclk) begin
        image_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                note_failure($sformatf("unexpected result status=%0d marker=%0b header=%0b",
                                       m_status, m_marker_seen, m_header_done));
            end else begin
                want = expected_results.pop_front();
                if (m_status !== want.status || m_marker_seen !== want.marker ||
                    m_header_done !== want.header)
                    note_failure($sformatf(
                        "mismatch exp status=%0d marker=%0b header=%0b, got %0d %0b %0b",
                        want.status, want.marker, want.header,
                        m_status, m_marker_seen, m_header_done));
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // Stimulus sequence
    initial begin
        int goal;
        int len;
        int sent;
        int mode;
        int sel;
        cfg_declared = DECLARED_SIZE_RST;
        cfg_max      = MAX_SIZE_RST;
        cfg_magic    = MAGIC_BYTE_RST;
        cfg_chip     = CHIP_CODE_RST;
        clear_transfer();
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: data before any start, unused action, bare finish
        push_req(ACT_DATA, 8'h00);
        push_req(ACT_DATA, 8'hFF);
        push_req(ACT_NONE, 8'hA5);
        push_req(ACT_FINISH, 8'h3C);
        push_req(ACT_START, 8'h00);
        // size limits around the minimum and the maximum
        write_reg(REG_DECLARED_SIZE, 32'd4096);
        write_reg(REG_MAX_SIZE, 32'd4095);
        push_req(ACT_START, 8'h00);
        write_reg(REG_DECLARED_SIZE, 32'd4095);
        write_reg(REG_MAX_SIZE, 32'hFFFFFF);
        push_req(ACT_START, 8'h00);
        write_reg(REG_DECLARED_SIZE, 32'hFFFFFF);
        push_req(ACT_START, 8'hFF);
        push_req(ACT_DATA, 8'h5A);
        push_req(ACT_FINISH, 8'hFF);
        write_reg(REG_MAX_SIZE, 32'd0);
        push_req(ACT_START, 8'h00);
        write_reg(REG_MAX_SIZE, 32'hFFFFFF);
        write_reg(REG_DECLARED_SIZE, 32'd40);

        // Random transfers in three backpressure phases
        for (int ph = 0; ph < 3; ph++) begin
            wait_drained();
            case (ph)
                0: begin
                    send_idle_pct = 19;
                    recv_idle_pct = 55;
                    write_reg(REG_MAGIC_BYTE, 32'd0);
                    write_reg(REG_CHIP_CODE, 32'hFFFF);
                end
                1: begin
                    send_idle_pct = 55;
                    recv_idle_pct = 19;
                    write_reg(REG_MAGIC_BYTE, 32'd255);
                    write_reg(REG_CHIP_CODE, 32'd0);
                    write_reg(REG_MAX_SIZE, 32'd4095);
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    write_reg(REG_MAGIC_BYTE, $urandom);
                    write_reg(REG_CHIP_CODE, $urandom);
                    write_reg(REG_MAX_SIZE, 32'hFFFFFF);
                end
            endcase
            goal = items_queued + 160;
            while (items_queued < goal) begin
                sel = $urandom_range(99);
                if (sel < 78) begin
                    if (cfg_declared > 100 || $urandom_range(1))
                        write_reg(REG_DECLARED_SIZE, ($urandom_range(9) == 0) ?
                                  $urandom_range(0, 30) : $urandom_range(24, 80));
                    len  = cfg_declared;
                    mode = $urandom_range(99);
                    if (mode < 70) sent = len;
                    else if (mode < 85) sent = $urandom_range(0, len);
                    else sent = len + $urandom_range(1, 3);
                    queue_image(len, sent, $urandom_range(99) < 80, $urandom_range(99) < 80,
                                $urandom_range(99) < 75, $urandom_range(99) < 8);
                end else if (sel < 94) begin
                    // loose requests outside any well-formed transfer
                    repeat ($urandom_range(1, 6))
                        push_req(action_t'($urandom_range(3)), 8'($urandom_range(255)));
                end else begin
                    // sender holds off until the block has drained
                    wait_drained();
                end
            end
        end

        wait_drained();
        repeat (10) @(negedge aclk);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/fisc_pkg.sv
rtl/firmware_image_stream_checker.sv
tb/tb_top.sv
